// File: sv/lzss_pkg.sv
// lzss decompressor package: window geometry, token constants and the
// command struct passed from the token parser to the copy engine
// no dependencies
`default_nettype none

package lzss_pkg;

	localparam int WINDOW_SIZE = 4096;
	localparam int ADDR_W      = $clog2(WINDOW_SIZE);

	typedef logic [ADDR_W-1:0] waddr_t;
	typedef logic [ADDR_W:0]   wcount_t;
	typedef logic [4:0]        run_len_t;

	// write pointer after reset and after a stream ends
	localparam waddr_t START_PTR = waddr_t'(32'hfee % WINDOW_SIZE);
	// shortest match, added to the 4-bit length code
	localparam run_len_t MIN_MATCH = 5'd3;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_LIT,
		CMD_MATCH
	} cmd_kind_t;

	typedef struct packed {
		logic       valid;
		cmd_kind_t  kind;
		logic [7:0] lit;
		logic [11:0] offset;
		logic [3:0] len_code;
		logic       last;
	} lzss_cmd_t;

endpackage

`default_nettype wire

// File: sv/lzss_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module lzss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/lzss_copy.sv
// lzss copy engine: history window ram, write pointer, fill count,
// match copy sequencer with forwarding, and the output register
// depends on lzss_pkg and lzss_ram
`default_nettype none

module lzss_copy (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lzss_pkg::lzss_cmd_t cmd,
	output logic                   cmd_ready,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [7:0]             m_axis_tdata,  // out_byte
	output logic                   m_axis_tlast
);

	import lzss_pkg::*;

	function automatic waddr_t wrap_inc(input waddr_t a);
		return (a == waddr_t'(WINDOW_SIZE - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic waddr_t reduce_off(input logic [11:0] off);
		logic [12:0] v;
		v = {1'b0, off};
		for (int k = 0; k < 3; k++) begin
			if (v >= 13'(WINDOW_SIZE)) begin
				v = v - 13'(WINDOW_SIZE);
			end
		end
		return waddr_t'(v);
	endfunction

	logic     busy_q, last_q, out_valid_q, out_last_q;
	logic [7:0] out_data_q;
	waddr_t   wp_q, rd_addr_q;
	wcount_t  count_q;
	run_len_t remain_q;

	logic       valid_s1, fwd_s1, hit_s1, final_s1;
	logic [7:0] fwd_data_s1;

	logic       out_free, lit_go, match_go, nop_go, adv_s1, issue, we, fwd, hit;
	logic [7:0] rdata, byte_s1, wdata;
	wcount_t    rel;

	assign out_free  = !out_valid_q || m_axis_tready;
	assign cmd_ready = !busy_q && out_free;
	assign lit_go    = cmd.valid && cmd_ready && (cmd.kind == CMD_LIT);
	assign match_go  = cmd.valid && cmd_ready && (cmd.kind == CMD_MATCH);
	assign nop_go    = cmd.valid && cmd_ready && (cmd.kind == CMD_NOP);

	assign adv_s1  = valid_s1 && out_free;
	assign issue   = busy_q && (remain_q != '0) && (!valid_s1 || adv_s1);

	// never-written entries read as zero
	assign byte_s1 = fwd_s1 ? fwd_data_s1 : (hit_s1 ? rdata : 8'h00);

	assign we    = lit_go || adv_s1;
	assign wdata = lit_go ? cmd.lit : byte_s1;
	// read of the entry being written this very cycle
	assign fwd   = we && (rd_addr_q == wp_q);

	// entries are filled in order from START_PTR, so written ones form one range
	assign rel = (rd_addr_q >= START_PTR) ?
		({1'b0, rd_addr_q} - {1'b0, START_PTR}) :
		({1'b0, rd_addr_q} + wcount_t'(WINDOW_SIZE) - {1'b0, START_PTR});
	assign hit = rel < count_q;

	lzss_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_SIZE)
	) u_window (
		.clk   (clk),
		.we    (we),
		.waddr (wp_q),
		.wdata (wdata),
		.re    (issue),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			valid_s1    <= 1'b0;
			wp_q        <= START_PTR;
			count_q     <= '0;
			remain_q    <= '0;
			rd_addr_q   <= '0;
		end else begin
			// window pointer and fill count, restarted when a stream ends
			if ((lit_go && cmd.last) || (nop_go && cmd.last) ||
					(adv_s1 && final_s1 && last_q)) begin
				wp_q    <= START_PTR;
				count_q <= '0;
			end else if (we) begin
				wp_q <= wrap_inc(wp_q);
				if (count_q != wcount_t'(WINDOW_SIZE)) begin
					count_q <= count_q + 1'b1;
				end
			end

			// copy sequencer
			if (match_go) begin
				busy_q    <= 1'b1;
				last_q    <= cmd.last;
				rd_addr_q <= reduce_off(cmd.offset);
				remain_q  <= {1'b0, cmd.len_code} + MIN_MATCH;
			end else if (adv_s1 && final_s1) begin
				busy_q <= 1'b0;
				last_q <= 1'b0;
			end
			if (issue) begin
				rd_addr_q <= wrap_inc(rd_addr_q);
				remain_q  <= remain_q - 1'b1;
			end

			// read stage
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end

			// output register
			if (out_free) begin
				out_valid_q <= lit_go || adv_s1;
				out_last_q  <= lit_go || final_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			fwd_s1      <= fwd;
			fwd_data_s1 <= wdata;
			hit_s1      <= hit;
			final_s1    <= (remain_q == run_len_t'(1));
		end
		if (out_free) begin
			out_data_q <= wdata;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: sv/lzss_decompressor.sv
// lzss decompressor top level: token parser feeding the copy engine
// depends on lzss_pkg and lzss_copy
//
// usage:
// - s_axis carries compressed bytes, one per beat; s_axis_tlast marks the
//   final byte of a stream, after which the window and the parser restart
// - m_axis carries decompressed bytes; m_axis_tlast is set on the last byte
//   that one input beat produces (a literal, or the end of a match copy)
// - flag bytes and the first byte of a match produce no output beat
// - a literal shows up on m_axis in the cycle after its beat is taken
// - a match of n bytes (3..18) shows its first byte once the second match
//   byte has passed the read address register, the window ram read and the
//   output register, then one byte a cycle while m_axis_tready is high;
//   s_axis_tready is low until the copy ends
// - a copy may read the byte being written in the same cycle; that byte is
//   forwarded around the ram
// - reset starts the parser at a flag byte and empties the window (a fill
//   count makes unwritten entries read as zero, so there is no clear pass)
// - when m_axis_tready is low the output register holds its beat and the
//   copy pauses; s_axis_tready drops while the output register is full
//   and not being taken
`default_nettype none

module lzss_decompressor (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // in_byte
	input  wire logic       s_axis_tlast,  // last_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // out_byte
	output logic            m_axis_tlast   // run_last
);

	import lzss_pkg::*;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_FIRST,
		PH_SECOND
	} phase_t;

	phase_t     phase_q, phase_nxt;
	logic [7:0] flag_q, flag_nxt, off_lo_q, off_lo_nxt;
	logic [3:0] bits_q, bits_nxt, bits_dec;
	logic       accept, cmd_ready;
	lzss_cmd_t  cmd;

	assign accept        = s_axis_tvalid && cmd_ready;
	assign s_axis_tready = cmd_ready;
	assign bits_dec      = (bits_q != 4'd0) ? bits_q - 4'd1 : 4'd0;

	// token decode and next parse state
	always_comb begin
		cmd          = '0;
		cmd.valid    = accept;
		cmd.kind     = CMD_NOP;
		cmd.lit      = s_axis_tdata;
		cmd.offset   = {s_axis_tdata[7:4], off_lo_q};
		cmd.len_code = s_axis_tdata[3:0];
		cmd.last     = s_axis_tlast;
		phase_nxt    = phase_q;
		flag_nxt     = flag_q;
		bits_nxt     = bits_q;
		off_lo_nxt   = off_lo_q;
		case (phase_q)
			PH_FIRST: begin
				if (flag_q[0]) begin
					// literal token
					cmd.kind  = CMD_LIT;
					flag_nxt  = flag_q >> 1;
					bits_nxt  = bits_dec;
					phase_nxt = (bits_dec == 4'd0) ? PH_FLAG : PH_FIRST;
				end else begin
					off_lo_nxt = s_axis_tdata;
					phase_nxt  = PH_SECOND;
				end
			end
			PH_SECOND: begin
				// match token: offset high nibble and length code
				cmd.kind  = CMD_MATCH;
				flag_nxt  = flag_q >> 1;
				bits_nxt  = bits_dec;
				phase_nxt = (bits_dec == 4'd0) ? PH_FLAG : PH_FIRST;
			end
			default: begin
				flag_nxt  = s_axis_tdata;
				bits_nxt  = 4'd8;
				phase_nxt = PH_FIRST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FLAG;
			flag_q   <= '0;
			bits_q   <= '0;
			off_lo_q <= '0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				// end of stream: a cut-off token is dropped
				phase_q  <= PH_FLAG;
				flag_q   <= '0;
				bits_q   <= '0;
				off_lo_q <= '0;
			end else begin
				phase_q  <= phase_nxt;
				flag_q   <= flag_nxt;
				bits_q   <= bits_nxt;
				off_lo_q <= off_lo_nxt;
			end
		end
	end

	lzss_copy u_copy (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cmd_ready     (cmd_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// File: tb/lzss_checker.sv
`timescale 1ns / 100ps
// lzss decompressor checker: watches both stream channels, decodes every
// accepted compressed beat into the bytes it must produce and compares them
// depends on lzss_pkg for the window geometry and the start pointer

module lzss_checker
	import lzss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,
	input  logic       s_axis_tlast,
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,
	input  logic       m_axis_tlast,
	output int         errors,
	output int         pending
);

	typedef enum logic [1:0] {
		WANT_FLAG,
		WANT_FIRST,
		WANT_SECOND
	} parse_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	logic [7:0]   history [WINDOW_SIZE];
	waddr_t       wr_ptr;
	logic [7:0]   token_bits;
	logic [3:0]   bits_left;
	parse_state_t parse_state;
	logic [7:0]   offset_lo;
	out_beat_t    expected_bytes[$];
	int           fail_count;
	int           produced;

	task automatic restart_stream();
		for (int i = 0; i < WINDOW_SIZE; i++)
			history[i] = 8'h00;
		wr_ptr      = START_PTR;
		token_bits  = 8'h00;
		bits_left   = 4'd0;
		parse_state = WANT_FLAG;
		offset_lo   = 8'h00;
	endtask

	task automatic put_byte(input logic [7:0] b);
		history[wr_ptr] = b;
		wr_ptr = (wr_ptr == waddr_t'(WINDOW_SIZE - 1)) ? '0 : wr_ptr + 1'b1;
		expected_bytes.push_back('{data: b, last: 1'b0});
		produced++;
	endtask

	task automatic next_token();
		token_bits = token_bits >> 1;
		if (bits_left != 0)
			bits_left--;
		parse_state = (bits_left == 0) ? WANT_FLAG : WANT_FIRST;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic stream_end);
		logic [11:0] match_off;
		int          match_len;
		out_beat_t   tail;
		produced = 0;
		case (parse_state)
			WANT_FIRST: begin
				if (token_bits[0]) begin
					put_byte(b);
					next_token();
				end else begin
					offset_lo   = b;
					parse_state = WANT_SECOND;
				end
			end
			WANT_SECOND: begin
				match_off = {b[7:4], offset_lo};
				match_len = int'(b[3:0]) + 3;
				// byte by byte, so an overlapping copy sees what it just wrote
				for (int i = 0; i < match_len; i++)
					put_byte(history[(int'(match_off) + i) % WINDOW_SIZE]);
				next_token();
			end
			default: begin
				token_bits  = b;
				bits_left   = 4'd8;
				parse_state = WANT_FIRST;
			end
		endcase
		if (produced > 0) begin
			tail = expected_bytes.pop_back();
			tail.last = 1'b1;
			expected_bytes.push_back(tail);
		end
		if (stream_end)
			restart_stream();
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		fail_count++;
	endtask

	task automatic check_out_beat();
		out_beat_t want;
		if (expected_bytes.size() == 0) begin
			report_mismatch($sformatf("unexpected output beat data %02h last %0b",
				m_axis_tdata, m_axis_tlast));
		end else begin
			want = expected_bytes.pop_front();
			if (m_axis_tdata !== want.data)
				report_mismatch($sformatf("out_byte %02h, expected %02h",
					m_axis_tdata, want.data));
			if (m_axis_tlast !== want.last)
				report_mismatch($sformatf("run_last %0b, expected %0b",
					m_axis_tlast, want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_stream();
			expected_bytes.delete();
			fail_count = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				check_out_beat();
			errors  <= fail_count;
			pending <= expected_bytes.size();
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// lzss decompressor testbench top: clock, reset, compressed stream stimulus,
// output back-pressure and the verdict; checking lives in lzss_checker
// depends on lzss_pkg, lzss_decompressor and lzss_checker

module tb;
	import lzss_pkg::*;

	localparam int PHASE_BYTES    = 70;   // compressed beats per random phase
	localparam int HOLD_CYCLES    = 300;  // long output hold-off
	localparam int QUIET_LIMIT    = 3000; // cycles with no beat on either side
	localparam int SETTLE_CYCLES  = 50;   // a full match plus some slack

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tready = 1'b0;
	wire logic       s_tready;
	wire logic       m_tvalid;
	wire logic [7:0] m_tdata;
	wire logic       m_tlast;

	int errors;
	int pending;

	// idle chances in percent, changed between phases
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// set by the stimulus, picked up and cleared by the receiver
	bit hold_req = 1'b0;
	int bytes_sent = 0;
	int quiet_cycles = 0;

	// compressed bytes of the stream being sent
	logic [7:0] stream_q[$];

	always #5 clk = ~clk;

	lzss_decompressor u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),   // in_byte
		.s_axis_tlast  (s_tlast),   // last_byte
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),   // out_byte
		.m_axis_tlast  (m_tlast)    // run_last
	);

	lzss_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tlast  (m_tlast),
		.errors        (errors),
		.pending       (pending)
	);

	// reset held from time zero, released on a rising edge
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver: random back-pressure, plus one long hold-off on request so
	// the block fills up and has to stall its input
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog: a stuck handshake or a missing output beat ends up here
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// offer one compressed byte, maybe after idle cycles, and wait for the beat
	task automatic send_beat(input logic [7:0] b, input logic stream_end);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= stream_end;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// send the queued stream, tlast on its final byte
	task automatic send_stream();
		for (int i = 0; i < stream_q.size(); i++)
			send_beat(stream_q[i], i == stream_q.size() - 1);
	endtask

	// stop offering and wait until every expected output byte has come
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// build one random stream: mostly well-formed tokens with random content,
	// some pure noise, and some cut off at a random byte so the final token
	// may be dropped half way
	task automatic build_stream();
		int          ptr;
		int          ntok;
		int          back_off;
		int          len_code;
		logic [7:0]  flags;
		logic [11:0] off;
		int          keep;
		stream_q.delete();
		ptr   = int'(START_PTR);
		flags = 8'h00;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 20))
				stream_q.push_back(8'($urandom_range(255)));
		end else begin
			ntok = $urandom_range(1, 20);
			for (int t = 0; t < ntok; t++) begin
				if (t % 8 == 0) begin
					case ($urandom_range(7))
						0:       flags = 8'h00;   // all matches
						1:       flags = 8'hff;   // all literals
						default: flags = 8'($urandom_range(255));
					endcase
					stream_q.push_back(flags);
				end
				if (flags[t % 8]) begin
					stream_q.push_back(8'($urandom_range(255)));
					ptr = (ptr + 1) % WINDOW_SIZE;
				end else begin
					// recent offsets give overlapping copies of real data,
					// far ones mostly read the cleared window
					case ($urandom_range(3))
						0, 1:    back_off = $urandom_range(1, 20);
						2:       back_off = $urandom_range(1, 600);
						default: back_off = $urandom_range(WINDOW_SIZE - 1);
					endcase
					off      = 12'((ptr + WINDOW_SIZE - back_off) % WINDOW_SIZE);
					len_code = $urandom_range(15);
					stream_q.push_back(off[7:0]);
					stream_q.push_back({off[11:8], 4'(len_code)});
					ptr = (ptr + len_code + 3) % WINDOW_SIZE;
				end
			end
			if ($urandom_range(3) == 0) begin
				keep = $urandom_range(1, stream_q.size());
				while (stream_q.size() > keep)
					void'(stream_q.pop_back());
			end
		end
	endtask

	initial begin
		int phase_start;
		bit held;
		bit paused;

		do @(posedge clk); while (!arst_n);

		// directed, write pointer starts at 0xfee:
		// literals 00 and ff, an 18-byte copy overlapping its own output and
		// wrapping the pointer past 0xfff, a 3-byte copy from offset 0 (just
		// written after the wrap), a copy from never-written entries, more
		// literals, an all-match flag, a copy from 0x010, then the stream cut
		// after a match's first byte
		stream_q = '{8'he3, 8'h00, 8'hff, 8'hee, 8'hff, 8'h00, 8'h00,
			8'h00, 8'h85, 8'h55, 8'haa, 8'h0f, 8'h00, 8'h10, 8'h02, 8'h34};
		send_stream();
		// stream that ends on its flag byte
		stream_q = '{8'hff};
		send_stream();
		// stream that ends on a literal
		stream_q = '{8'h01, 8'h80};
		send_stream();
		// copy from 0xfee must now read zeros: the window was cleared
		stream_q = '{8'h00, 8'hee, 8'hf0};
		send_stream();
		wait_drained();

		// random phases: sender idles 33 / receiver 67, then the reverse,
		// then no idling at all
		held = 1'b0;
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 33;
					recv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					recv_idle_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			phase_start = bytes_sent;
			paused = 1'b0;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				// long output hold-off while the sender keeps going
				if (p == 2 && !held) begin
					hold_req = 1'b1;
					held = 1'b1;
				end
				// sender pause mid-phase until the block has emptied
				if (!paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				build_stream();
				send_stream();
			end
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
sv/lzss_pkg.sv
sv/lzss_ram.sv
sv/lzss_copy.sv
sv/lzss_decompressor.sv
tb/lzss_checker.sv
tb/tb.sv
